@@ src/current_error_fault_accumulator_unit_defines.svh @@
// Assertion macros for the fault accumulator RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CURRENT_ERROR_FAULT_ACCUMULATOR_UNIT_DEFINES_SVH
`define CURRENT_ERROR_FAULT_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CEFA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CEFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cefa_pkg.sv @@
// Types and constants for the current error fault accumulator.
// No dependencies.
package cefa_pkg;

    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_USE_ALT   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ALLOWANCE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CEILING   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GAIN_HIGH = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_GAIN_LOW  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DECAY     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd6;

    localparam logic [14:0] CEILING_RESET   = 15'h7FFF;
    localparam logic [31:0] THRESHOLD_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        use_alt_reference;
        logic [14:0] error_allowance;
        logic [14:0] error_ceiling;
        logic [15:0] gain_high;
        logic [15:0] gain_low;
        logic [31:0] decay_step;
        logic [31:0] fail_threshold;
    } cefa_cfg_t;

    typedef struct packed {
        logic        [15:0] supply_voltage;
        logic        [15:0] modulation_index;
        logic signed [15:0] measured_current;
        logic signed [15:0] reference_main;
        logic signed [15:0] reference_alt;
    } cefa_item_t;

    // counter update request: add inc, or decay
    typedef struct packed {
        logic        add_en;
        logic [30:0] inc;
    } cefa_step_t;

endpackage

@@ src/cefa_cfg_regs.sv @@
// Configuration register file of the fault accumulator.
// Depends on cefa_pkg.
module cefa_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [cefa_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [31:0]                   cfg_data,
    output cefa_pkg::cefa_cfg_t           cfg
);

    cefa_pkg::cefa_cfg_t cfg_reg;
    cefa_pkg::cefa_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cefa_pkg::REG_USE_ALT:   cfg_next.use_alt_reference = cfg_data[0];
                cefa_pkg::REG_ALLOWANCE: cfg_next.error_allowance   = cfg_data[14:0];
                cefa_pkg::REG_CEILING:   cfg_next.error_ceiling     = cfg_data[14:0];
                cefa_pkg::REG_GAIN_HIGH: cfg_next.gain_high         = cfg_data[15:0];
                cefa_pkg::REG_GAIN_LOW:  cfg_next.gain_low          = cfg_data[15:0];
                cefa_pkg::REG_DECAY:     cfg_next.decay_step        = cfg_data;
                cefa_pkg::REG_THRESHOLD: cfg_next.fail_threshold    = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_alt_reference <= 1'b0;
            cfg_reg.error_allowance   <= '0;
            cfg_reg.error_ceiling     <= cefa_pkg::CEILING_RESET;
            cfg_reg.gain_high         <= '0;
            cfg_reg.gain_low          <= '0;
            cfg_reg.decay_step        <= '0;
            cfg_reg.fail_threshold    <= cefa_pkg::THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/cefa_excess_stage.sv @@
// Excess error, saturation test and gain product for one item; registered.
// Depends on cefa_pkg.
module cefa_excess_stage
(
    input  logic                 clk,
    input  logic                 load,
    input  cefa_pkg::cefa_item_t item,
    input  cefa_pkg::cefa_cfg_t  cfg,
    output cefa_pkg::cefa_step_t step
);

    logic signed [15:0] ref_sel;
    logic signed [16:0] diff;
    logic        [16:0] abs_diff;
    logic        [16:0] abs_ref;
    logic        [16:0] abs_meas;
    logic signed [17:0] err_raw;
    logic signed [17:0] err_clamped;
    logic               err_pos;
    logic               overshoot;
    logic        [31:0] volt_prod;
    logic               saturated;
    logic        [15:0] gain_sel;
    logic        [30:0] product;
    cefa_pkg::cefa_step_t step_reg;
    cefa_pkg::cefa_step_t step_next;

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = {v[15], v};
        return w[16] ? 17'(-w) : 17'(w);
    endfunction

    always_comb
    begin
        ref_sel  = cfg.use_alt_reference ? item.reference_alt : item.reference_main;
        diff     = {ref_sel[15], ref_sel} - {item.measured_current[15], item.measured_current};
        abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
        abs_ref  = mag16(ref_sel);
        abs_meas = mag16(item.measured_current);

        err_raw = $signed({1'b0, abs_diff}) - $signed({3'b000, cfg.error_allowance});
        if (err_raw >= $signed({3'b000, cfg.error_ceiling}))
            err_clamped = $signed({3'b000, cfg.error_ceiling});
        else
            err_clamped = err_raw;
        err_pos = !err_clamped[17] && (err_clamped != '0);

        // Q18.14 product against supply << 14; zero supply counts as saturated
        volt_prod = item.modulation_index * item.supply_voltage;
        saturated = volt_prod >= {2'b00, item.supply_voltage, 14'd0};

        overshoot = abs_meas > abs_ref;
        gain_sel  = overshoot ? cfg.gain_high : cfg.gain_low;
        product   = gain_sel * err_clamped[14:0];

        step_next.add_en = err_pos && (overshoot || !saturated);
        step_next.inc    = product;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            step_reg <= step_next;
    end

    assign step = step_reg;

endmodule

@@ src/cefa_counter.sv @@
// Fault counter with saturating add, floored decay and the result register.
// Depends on cefa_pkg and the assertion macros header.
`include "current_error_fault_accumulator_unit_defines.svh"
module cefa_counter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_valid,
    input  cefa_pkg::cefa_step_t step,
    input  cefa_pkg::cefa_cfg_t  cfg,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 fault,
    output logic [31:0]          counter_value
);

    logic [31:0] counter_reg;
    logic [31:0] counter_next;
    logic        fault_reg;
    logic        out_valid_reg;
    logic [32:0] sum;
    logic [31:0] add_val;
    logic [31:0] dec_val;

    always_comb
    begin
        sum     = {1'b0, counter_reg} + {2'b00, step.inc};
        add_val = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        dec_val = (counter_reg > cfg.decay_step) ? counter_reg - cfg.decay_step : 32'd0;
        counter_next = step.add_en ? add_val : dec_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_valid)
            begin
                counter_reg   <= counter_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_valid)
            fault_reg <= counter_next > cfg.fail_threshold;
    end

    assign out_valid     = out_valid_reg;
    assign fault         = fault_reg;
    assign counter_value = counter_reg;

    `CEFA_ASSERT_NEXT(a_hold_when_idle, !step_valid, $stable(counter_reg), "counter moved without an item")
    `CEFA_ASSERT_NEXT(a_decay_no_rise, step_valid && !step.add_en, counter_reg <= $past(counter_reg), "decay raised counter")
    `CEFA_ASSERT_IMPL(a_fault_match, out_valid_reg, fault_reg == (counter_reg > cfg.fail_threshold), "fault flag mismatch")

endmodule

@@ src/current_error_fault_accumulator_unit.sv @@
// Top level of the current error fault accumulator.
// Depends on cefa_pkg, cefa_cfg_regs, cefa_excess_stage and cefa_counter.
//
// Usage:
//  - s_axis: one item per tick; tdata = reference_alt, reference_main,
//    measured_current, modulation_index, supply_voltage (16 bits each).
//  - m_axis: one result per item; tdata = fault, counter_value, padded.
//  - cfg: write channel (cfg_valid/cfg_ready, cfg_index, cfg_data), always
//    ready; write only while no item is in flight. Unknown indexes ignored.
//  - Pipeline: input register -> excess/product register -> counter and
//    result register. m_axis_tvalid rises when an accepted item reaches
//    the result register.
//  - Throughput: 1 item per cycle unless stalled. The counter add/decay
//    closes on its own register, so back-to-back items see the fresh count.
//  - Stall: each stage advances when the one after it is empty or moving;
//    with m_axis_tready low, up to two more items are taken before
//    s_axis_tready drops. The held result stays stable.
//  - Reset: counter cleared, pipeline emptied, registers back to defaults
//    (ceiling 0x7FFF, threshold 0xFFFFFFFF, all others zero).
module current_error_fault_accumulator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] reference_alt, [31:16] reference_main, [47:32] measured_current,
    // [63:48] modulation_index, [79:64] supply_voltage
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] fault, [32:1] counter_value, [39:33] zero
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cefa_pkg::cefa_cfg_t  cfg;
    cefa_pkg::cefa_item_t item_reg;
    cefa_pkg::cefa_step_t step;
    logic        in_valid_reg;
    logic        step_valid_reg;
    logic        out_valid;
    logic        out_ok;
    logic        step_move;
    logic        step_ok;
    logic        item_move;
    logic        in_fire;
    logic        fault;
    logic [31:0] counter_value;

    // stage advance chain, back to front
    assign out_ok        = !out_valid || m_axis_tready;
    assign step_move     = step_valid_reg && out_ok;
    assign step_ok       = !step_valid_reg || out_ok;
    assign item_move     = in_valid_reg && step_ok;
    assign s_axis_tready = !in_valid_reg || step_ok;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            step_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (item_move)
                in_valid_reg <= 1'b0;

            if (item_move)
                step_valid_reg <= 1'b1;
            else if (step_move)
                step_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= s_axis_tdata;
    end

    cefa_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cefa_excess_stage u_excess
    (
        .clk  (clk),
        .load (item_move),
        .item (item_reg),
        .cfg  (cfg),
        .step (step)
    );

    cefa_counter u_counter
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_valid    (step_move),
        .step          (step),
        .cfg           (cfg),
        .out_ready     (m_axis_tready),
        .out_valid     (out_valid),
        .fault         (fault),
        .counter_value (counter_value)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'd0, counter_value, fault};

endmodule
